### src/debug_packet_receiver_macros.svh
// assertion macros shared by the debug packet receiver modules
// expects i_clk and i_rst_n in the scope of use
`ifndef DEBUG_PACKET_RECEIVER_MACROS_SVH
`define DEBUG_PACKET_RECEIVER_MACROS_SVH

// same-cycle implication, checked outside reset
`define DPR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/dpr_pkg.sv
// types, character codes and hex decode for the debug packet receiver
// no dependencies
package dpr_pkg;

    localparam logic [6:0] CH_START = 7'h24;  // '$'
    localparam logic [6:0] CH_END   = 7'h23;  // '#'
    localparam logic [6:0] CH_INTR  = 7'h03;
    localparam logic [6:0] CH_ACK   = 7'h2b;  // '+'
    localparam logic [6:0] CH_NAK   = 7'h2d;  // '-'
    localparam logic [3:0] NIB_BAD  = 4'hf;

    typedef enum logic [2:0] {
        K_PAYLOAD = 3'd0,
        K_GOOD    = 3'd1,
        K_BAD     = 3'd2,
        K_INTR    = 3'd3,
        K_LOST    = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       link_lost;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] data;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

    // raw byte as hex digit, anything else maps to NIB_BAD
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = {4'h0, NIB_BAD};
        if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
        end else if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

endpackage

### src/dpr_deframe.sv
// input register, deframing state machine and checksum accumulation
// depends on dpr_pkg and debug_packet_receiver_macros.svh
`include "debug_packet_receiver_macros.svh"

module dpr_deframe import dpr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_res_ready,
    output t_result  o_res
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CSUM_HI = 2'd2,
        PH_CSUM_LO = 2'd3
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_sum, n_sum;
    logic [3:0] r_hi, n_hi;
    logic       r_in_valid;
    t_in_item   r_in;
    logic       take;
    logic [6:0] low7;
    logic [7:0] rsum;
    t_result    res;

    assign take       = r_in_valid && i_res_ready;
    assign o_in_ready = !r_in_valid || i_res_ready;
    assign low7       = r_in.rx_byte[6:0];
    assign rsum       = {r_hi, hex_nibble(r_in.rx_byte)};

    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_hi    = r_hi;
        res     = '0;
        if (r_in.link_lost) begin
            n_phase        = PH_IDLE;
            n_sum          = '0;
            n_hi           = '0;
            res.valid      = 1'b1;
            res.item.kind  = K_LOST;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (low7 == CH_START) begin
                        n_sum   = '0;
                        n_phase = PH_PAYLOAD;
                    end else if (low7 == CH_INTR) begin
                        res.valid     = 1'b1;
                        res.item.kind = K_INTR;
                    end
                end
                PH_PAYLOAD: begin
                    if (low7 == CH_END) begin
                        n_phase = PH_CSUM_HI;
                    end else begin
                        n_sum         = r_sum + {1'b0, low7};
                        res.valid     = 1'b1;
                        res.item.kind = K_PAYLOAD;
                        res.item.data = low7;
                    end
                end
                PH_CSUM_HI: begin
                    n_hi    = hex_nibble(r_in.rx_byte);
                    n_phase = PH_CSUM_LO;
                end
                PH_CSUM_LO: begin
                    res.valid             = 1'b1;
                    res.item.kind         = (rsum == r_sum) ? K_GOOD : K_BAD;
                    res.item.data         = (rsum == r_sum) ? CH_ACK : CH_NAK;
                    res.item.computed_sum = r_sum;
                    res.item.received_sum = rsum;
                    n_phase               = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // result only counts when the byte is actually consumed
    always_comb begin
        o_res       = res;
        o_res.valid = res.valid && take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_sum      <= '0;
            r_hi       <= '0;
            r_in_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase;
                r_sum   <= n_sum;
                r_hi    <= n_hi;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    `DPR_ASSERT_NEXT(a_lost_clears, take && r_in.link_lost,
        r_phase == PH_IDLE && r_sum == 8'h00 && r_hi == 4'h0, "link lost did not clear state")
    `DPR_ASSERT_NEXT(a_hi_to_lo, take && !r_in.link_lost && r_phase == PH_CSUM_HI,
        r_phase == PH_CSUM_LO, "first checksum digit not followed by second")
    `DPR_ASSERT_NEXT(a_stall_holds, r_in_valid && !take,
        r_in_valid && $stable(r_in) && $stable(r_phase), "stalled byte lost or state moved")
    `DPR_ASSERT_IMPL(a_verdict_phase,
        o_res.valid && (o_res.item.kind == K_GOOD || o_res.item.kind == K_BAD),
        r_phase == PH_CSUM_LO && !r_in.link_lost, "verdict outside second checksum digit")

endmodule

### src/dpr_out_reg.sv
// result register toward the consumer side
// depends on dpr_pkg
module dpr_out_reg import dpr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_result   i_res,
    output logic      o_res_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_valid;
    t_out_item r_item;

    assign o_res_ready = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res.valid) begin
            r_item <= i_res.item;
        end
    end

endmodule

### src/debug_packet_receiver.sv
// debug packet receiver: deframes $payload#hh packets one byte per transfer
// path: a byte's result reaches o_out_valid through the deframer input register, then the output result register
// throughput: one byte per cycle while the output side is ready, set by the phase register and 8-bit adder
// reset (synchronous, i_rst_n low): idle phase, sum and nibble cleared, both registers empty
// depends on dpr_pkg, dpr_deframe and dpr_out_reg
module debug_packet_receiver import dpr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_result res;
    logic    res_ready;

    dpr_deframe u_deframe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    dpr_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### dv/testbench.sv
// testbench for debug_packet_receiver: directed framing and link-loss cases, then random packet traffic
// every output transfer is checked in order against a behavioral deframer kept here
// depends on dpr_pkg and debug_packet_receiver
module testbench import dpr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY      = 2;
    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int EXP_DEPTH    = 16;
    localparam int SEQ_MAX      = 64;

    typedef enum logic [1:0] {
        SEEK_START,
        IN_BODY,
        SUM_DIGIT_HI,
        SUM_DIGIT_LO
    } t_rx_phase;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // deframer state as the testbench sees it
    t_rx_phase  rx_phase = SEEK_START;
    logic [7:0] rx_sum   = '0;
    logic [3:0] rx_hi    = '0;

    // predicted results waiting for their output transfer
    t_out_item  exp_buf[EXP_DEPTH];
    logic [3:0] exp_wr    = '0;
    logic [3:0] exp_rd    = '0;
    int         exp_count = 0;

    int        error_count   = 0;
    int        items_sent    = 0;
    int        kind_seen[5]  = '{default: 0};
    bit        steady        = 1'b0;
    bit        in_valid_held = 1'b0;
    int        out_hold      = 0;

    debug_packet_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c[3:0];
        // low nibble of a-f and A-F is 1..6
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return c[3:0] + 4'd9;
        return NIB_BAD;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return 8'h30 + n;
        return (upper ? 8'h37 : 8'h57) + n;
    endfunction

    // advance the deframer by one byte, returns 1 when a result is due
    function automatic bit deframe_step(input t_in_item it, output t_out_item res);
        logic [6:0] low7;
        logic [7:0] rsum;
        bit         due;
        low7 = it.rx_byte[6:0];
        res  = '0;
        due  = 1'b0;
        if (it.link_lost) begin
            rx_phase = SEEK_START;
            rx_sum   = '0;
            rx_hi    = '0;
            res.kind = K_LOST;
            due      = 1'b1;
        end else begin
            case (rx_phase)
                SEEK_START: begin
                    if (low7 == CH_START) begin
                        rx_sum   = '0;
                        rx_phase = IN_BODY;
                    end else if (low7 == CH_INTR) begin
                        res.kind = K_INTR;
                        due      = 1'b1;
                    end
                end
                IN_BODY: begin
                    if (low7 == CH_END) begin
                        rx_phase = SUM_DIGIT_HI;
                    end else begin
                        rx_sum   = rx_sum + {1'b0, low7};
                        res.kind = K_PAYLOAD;
                        res.data = low7;
                        due      = 1'b1;
                    end
                end
                SUM_DIGIT_HI: begin
                    rx_hi    = digit_value(it.rx_byte);
                    rx_phase = SUM_DIGIT_LO;
                end
                default: begin
                    rsum             = {rx_hi, digit_value(it.rx_byte)};
                    res.kind         = (rsum == rx_sum) ? K_GOOD : K_BAD;
                    res.data         = (rsum == rx_sum) ? CH_ACK : CH_NAK;
                    res.computed_sum = rx_sum;
                    res.received_sum = rsum;
                    rx_phase         = SEEK_START;
                    due              = 1'b1;
                end
            endcase
        end
        return due;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // input and output transfers seen at the edge, prediction first
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (deframe_step(i_in_item, want)) begin
                    if (exp_count == EXP_DEPTH) begin
                        $error("prediction buffer overflow");
                        error_count++;
                    end else begin
                        exp_buf[exp_wr] = want;
                        exp_wr          = exp_wr + 4'd1;
                        exp_count++;
                    end
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (exp_count == 0) begin
                    $error("unexpected result: kind %0d data %0h", o_out_item.kind,
                           o_out_item.data);
                    error_count++;
                end else begin
                    want   = exp_buf[exp_rd];
                    exp_rd = exp_rd + 4'd1;
                    exp_count--;
                    check_field("kind", 8'(want.kind), 8'(o_out_item.kind));
                    check_field("data", 8'(want.data), 8'(o_out_item.data));
                    check_field("computed_sum", want.computed_sum, o_out_item.computed_sum);
                    check_field("received_sum", want.received_sum, o_out_item.received_sum);
                    kind_seen[int'(want.kind)]++;
                end
            end
        end
    end

    // receiver side: runs of ready broken by stalls of random length
    always @(posedge i_clk) begin
        if (out_hold > 0) begin
            out_hold <= out_hold - 1;
        end else if (steady || $urandom_range(0, 2) != 0) begin
            i_out_ready <= 1'b1;
            out_hold    <= $urandom_range(0, 8);
        end else begin
            i_out_ready <= 1'b0;
            out_hold    <= pick_gap();
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_item(input logic [7:0] b, input logic lost);
        t_in_item it;
        int       gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            if (in_valid_held) begin
                i_in_valid    <= 1'b0;
                in_valid_held  = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        it.rx_byte     = b;
        it.link_lost   = lost;
        i_in_valid    <= 1'b1;
        i_in_item     <= it;
        in_valid_held  = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic wait_all_results();
        if (in_valid_held) begin
            i_in_valid    <= 1'b0;
            in_valid_held  = 1'b0;
        end
        // let the monitor see the last input transfer first
        @(posedge i_clk);
        while (exp_count != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_item(8'($urandom), $urandom_range(0, 15) == 0);
    endtask

    // junk, start, body, end, two digits; sometimes cut short by a link loss
    task automatic send_random_packet();
        t_in_item   seq[SEQ_MAX];
        t_in_item   it;
        logic [7:0] sum;
        logic [7:0] rsum;
        int         n;
        int         len;
        int         r;
        int         cut;
        bit         upper;
        n            = 0;
        it.link_lost = 1'b0;
        repeat ($urandom_range(0, 3)) begin
            it.rx_byte = 8'($urandom);
            if ($urandom_range(0, 7) == 0) it.rx_byte = $urandom_range(0, 1) ? 8'h83 : 8'h03;
            if (it.rx_byte[6:0] == CH_START) it.rx_byte ^= 8'h01;
            seq[n] = it;
            n++;
        end
        it.rx_byte = {1'($urandom_range(0, 3) == 0), CH_START};
        seq[n] = it;
        n++;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
        sum = '0;
        repeat (len) begin
            it.rx_byte = 8'($urandom);
            if (it.rx_byte[6:0] == CH_END) it.rx_byte ^= 8'h01;
            sum = sum + {1'b0, it.rx_byte[6:0]};
            seq[n] = it;
            n++;
        end
        it.rx_byte = {1'($urandom_range(0, 3) == 0), CH_END};
        seq[n] = it;
        n++;
        r     = $urandom_range(0, 99);
        rsum  = (r < 65) ? sum : 8'($urandom);
        upper = 1'($urandom_range(0, 1));
        it.rx_byte = (r >= 90 && r < 95) ? 8'($urandom) : hex_char(rsum[7:4], upper);
        seq[n] = it;
        n++;
        it.rx_byte = (r >= 95) ? 8'($urandom) : hex_char(rsum[3:0], upper);
        seq[n] = it;
        n++;
        if ($urandom_range(0, 24) == 0) begin
            cut = $urandom_range(0, n - 1);
            n   = cut + 1;
            seq[cut].link_lost = 1'b1;
        end
        for (int i = 0; i < n; i++) send_item(seq[i].rx_byte, seq[i].link_lost);
    endtask

    task automatic test_framing();
        // interrupt bytes count only while hunting for a start, masked
        send_item(8'h03, 1'b0);
        send_item(8'h83, 1'b0);
        // start with top bit set, then bytes that look like control characters
        send_item(8'hA4, 1'b0);
        send_item(8'h03, 1'b0);
        send_item(8'h24, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hA3, 1'b0);
        // raw digit with top bit set is not hex
        send_item(8'hC1, 1'b0);
        send_item("F", 1'b0);
        // empty packet
        send_item("$", 1'b0);
        send_item("#", 1'b0);
        send_item("0", 1'b0);
        send_item("0", 1'b0);
        // good packet with lower-case digits
        send_item("$", 1'b0);
        send_item("x", 1'b0);
        send_item("y", 1'b0);
        send_item("#", 1'b0);
        send_item("f", 1'b0);
        send_item("1", 1'b0);
        wait_all_results();
    endtask

    task automatic test_link_lost();
        send_item(8'h24, 1'b1);
        send_item("$", 1'b0);
        send_item("k", 1'b0);
        send_item(8'hFF, 1'b1);
        send_item("$", 1'b0);
        send_item("#", 1'b0);
        send_item(8'h00, 1'b1);
        send_item("$", 1'b0);
        send_item("#", 1'b0);
        send_item("7", 1'b0);
        send_item(8'h83, 1'b1);
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                send_noise($urandom_range(4, 20));
            end else begin
                send_random_packet();
            end
            // now and then the sender holds off until the output side has drained
            if ($urandom_range(0, 59) == 0) wait_all_results();
        end
        wait_all_results();
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        repeat (15) send_random_packet();
        wait_all_results();
        steady = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_framing();
        test_link_lost();
        test_random_traffic();
        test_steady_stream();
        wait_all_results();
        $display("checked %0d input transfers: %0d payload bytes, %0d good, %0d bad verdicts",
                 items_sent, kind_seen[int'(K_PAYLOAD)], kind_seen[int'(K_GOOD)],
                 kind_seen[int'(K_BAD)]);
        $display("also %0d interrupts and %0d link-lost aborts, random stalls on both sides",
                 kind_seen[int'(K_INTR)], kind_seen[int'(K_LOST)]);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
